// ===== rtl/abs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// abs_pkg
// Shared types and constants of the ascending bubble sorter.
// ============================================================================
package abs_pkg;

    // Default capacity of the element store.
    localparam int MAX_ELEMENTS_DEF = 64;

    // Width of one element.
    localparam int VALUE_W = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PASS_START,
        ST_PASS_FIRST,
        ST_PASS_RUN,
        ST_PASS_LAST,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } seq_state_t;

    // Load request from the sequencer to the output register.
    typedef struct packed {
        logic                      load;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      trunc;
    } out_load_t;

endpackage

// ===== rtl/abs_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// abs_store
// Element store: one write port and one read port, read data registered.
// ============================================================================
module abs_store #(
    parameter int MAX_ELEMENTS = abs_pkg::MAX_ELEMENTS_DEF,
    parameter int ADDR_W       = $clog2(MAX_ELEMENTS)
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [abs_pkg::VALUE_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [abs_pkg::VALUE_W-1:0] rd_data
);
    import abs_pkg::*;

    logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: the read data is registered and appears in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/abs_out.sv =====
`timescale 1ns / 1ps
// ============================================================================
// abs_out
// Output register: holds one result beat until the receiver takes it.
// ============================================================================
module abs_out (
    input  logic                               clk,
    input  logic                               rst_n,
    input  abs_pkg::out_load_t                 out_load,
    output logic                               out_free,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [abs_pkg::VALUE_W-1:0] sorted_value,
    output logic                               end_of_run,
    output logic                               truncated
);
    import abs_pkg::*;

    logic                      valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      last_reg;
    logic                      trunc_reg;

    // Valid flag: set by a load, cleared when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_load.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (out_load.load)
        begin
            value_reg <= out_load.value;
            last_reg  <= out_load.last;
            trunc_reg <= out_load.trunc;
        end
    end

    // The register is free next cycle if it is empty or drains now.
    assign out_free     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign sorted_value = value_reg;
    assign end_of_run   = last_reg;
    assign truncated    = trunc_reg;

endmodule

// ===== rtl/abs_seq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// abs_seq
// Sequencer: collects elements, runs bubble passes over the store with a
// carry register, then reads the sorted elements out in order.
// ============================================================================
module abs_seq #(
    parameter int MAX_ELEMENTS = abs_pkg::MAX_ELEMENTS_DEF,
    parameter int ADDR_W       = $clog2(MAX_ELEMENTS),
    parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [abs_pkg::VALUE_W-1:0] value,
    input  logic                               final_item,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic signed [abs_pkg::VALUE_W-1:0] wr_data,
    output logic                               rd_en,
    output logic [ADDR_W-1:0]                  rd_addr,
    input  logic signed [abs_pkg::VALUE_W-1:0] rd_data,
    input  logic                               out_free,
    output abs_pkg::out_load_t                 out_load
);
    import abs_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ELEMENTS);

    seq_state_t                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [CNT_W-1:0]          len_reg, len_next;
    logic [ADDR_W-1:0]         j_reg, j_next;
    logic [ADDR_W-1:0]         k_reg, k_next;
    logic signed [VALUE_W-1:0] carry_reg, carry_next;

    logic             in_beat;
    logic             has_room;
    logic [CNT_W-1:0] count_inc;
    logic             carry_gt;
    logic             pass_more;
    logic [CNT_W-1:0] len_dec;
    logic             emit_last;

    // Shared decode terms.
    always_comb
    begin
        in_beat   = in_valid && (state_reg == ST_COLLECT);
        has_room  = count_reg < CAP;
        count_inc = count_reg + 1'b1;
        carry_gt  = carry_reg > rd_data;
        pass_more = (CNT_W'(j_reg) + 1'b1) < len_reg;
        len_dec   = len_reg - 1'b1;
        emit_last = (CNT_W'(k_reg) + 1'b1) == count_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_beat && final_item)
                begin
                    if (count_next > CNT_W'(1))
                    begin
                        state_next = ST_PASS_START;
                    end
                    else
                    begin
                        state_next = ST_EMIT_READ;
                    end
                end
            end
            ST_PASS_START: state_next = ST_PASS_FIRST;
            ST_PASS_FIRST: state_next = ST_PASS_RUN;
            ST_PASS_RUN:
            begin
                if (!pass_more)
                begin
                    state_next = ST_PASS_LAST;
                end
            end
            ST_PASS_LAST:
            begin
                if (len_dec > CNT_W'(1))
                begin
                    state_next = ST_PASS_START;
                end
                else
                begin
                    state_next = ST_EMIT_READ;
                end
            end
            ST_EMIT_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_LOAD;
                end
            end
            ST_EMIT_LOAD:
            begin
                if (emit_last)
                begin
                    state_next = ST_COLLECT;
                end
                else
                begin
                    state_next = ST_EMIT_READ;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Outputs and datapath next values.
    always_comb
    begin
        in_ready       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = carry_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        out_load       = '0;
        out_load.value = rd_data;
        out_load.last  = emit_last;
        out_load.trunc = ovf_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                k_next   = '0;
                if (in_beat)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[ADDR_W-1:0];
                        wr_data    = value;
                        count_next = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    len_next = count_next;
                end
            end
            ST_PASS_START:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_PASS_FIRST:
            begin
                carry_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(1);
                j_next     = ADDR_W'(1);
            end
            ST_PASS_RUN:
            begin
                // Keep the larger element moving right; write the smaller one back behind it.
                wr_en      = 1'b1;
                wr_addr    = j_reg - 1'b1;
                wr_data    = carry_gt ? rd_data : carry_reg;
                carry_next = carry_gt ? carry_reg : rd_data;
                if (pass_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg + 1'b1;
                    j_next  = j_reg + 1'b1;
                end
            end
            ST_PASS_LAST:
            begin
                wr_en    = 1'b1;
                wr_addr  = j_reg;
                wr_data  = carry_reg;
                len_next = len_dec;
                k_next   = '0;
            end
            ST_EMIT_READ:
            begin
                if (out_free)
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg;
                end
            end
            ST_EMIT_LOAD:
            begin
                out_load.load = 1'b1;
                if (emit_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        carry_reg <= carry_next;
    end

    // The read and the write never hit the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("store read and write address collide");

    // A result is loaded only after the output register was seen free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load.load |-> $past(out_free))
        else $error("output register overwritten");

    // The stored count stays within capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("element count beyond capacity");

    // A bubble pass never reaches past its active length.
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS_RUN) |-> (CNT_W'(j_reg) < len_reg))
        else $error("bubble pass index out of range");

endmodule

// ===== rtl/ascending_bubble_sorter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ascending_bubble_sorter
// Collects a set of signed elements and returns them in ascending order.
// ============================================================================
// Usage:
//   The input channel (in_valid / in_ready) takes one element per beat; the
//   beat with final_item high closes the set. in_ready is high only while
//   the block collects, one beat per cycle at most.
//   After the final beat the store is sorted in place by bubble passes. A
//   pass carries the larger element along in a register, with at most one
//   store read and one store write per cycle. Equal elements keep their
//   arrival order.
//   The output channel (out_valid / out_ready) then delivers one beat per
//   stored element; each is read from the store and loaded into the output
//   register before the next read starts. end_of_run marks the last beat;
//   truncated is set on every beat of a set that dropped elements beyond
//   MAX_ELEMENTS. A stalled receiver holds the output register and pauses the
//   read-out; the next set may be collected while the last beat still waits.
//   Reset clears the control state; the store needs no clearing pass.
// ============================================================================
module ascending_bubble_sorter #(
    parameter int MAX_ELEMENTS = abs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [abs_pkg::VALUE_W-1:0] value,
    input  logic                               final_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [abs_pkg::VALUE_W-1:0] sorted_value,
    output logic                               end_of_run,
    output logic                               truncated
);
    import abs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      out_free;
    out_load_t                 out_load;

    // Sort sequencer.
    abs_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W),
        .CNT_W        (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .final_item (final_item),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_free   (out_free),
        .out_load   (out_load)
    );

    // Element store.
    abs_store #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register.
    abs_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .out_load     (out_load),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .end_of_run   (end_of_run),
        .truncated    (truncated)
    );

endmodule

// ===== bench/tb_ascending_bubble_sorter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_ascending_bubble_sorter
// Self-checking bench for the ascending bubble sorter.
// ============================================================================
// Sets of signed elements are sent one beat at a time. The final beat of each
// set closes it. A behavioral sorter in the bench keeps its own copy of the
// element store. It predicts the ascending read-out of every closed set,
// including the truncated flag when the store overflows. Each output beat is
// checked field by field against the oldest predicted beat. Directed sets
// cover the value extremes, a single element, ordered and reversed input, a
// store filled exactly, and a store that overflows on both a middle beat and
// the final beat. Random sets follow, with bursts of idle cycles on both
// channels. A long output hold-off fills the block so that it stalls its
// input. The run ends with back-to-back traffic that has no idle cycles.
// ============================================================================
module tb_ascending_bubble_sorter;

    import abs_pkg::*;

    typedef logic signed [VALUE_W-1:0] elem_t;

    // One output beat as the bench expects it.
    typedef struct packed {
        elem_t value;
        logic  last;
        logic  trunc;
    } sorted_beat_t;

    localparam int    CAPACITY    = MAX_ELEMENTS_DEF;
    localparam int    HOLD_CYCLES = 400;
    localparam int    DRAIN_WAIT  = 4 * CAPACITY;
    localparam int    CYCLE_LIMIT = 400_000;
    localparam elem_t ELEM_MAX    = 32'sh7FFF_FFFF;
    localparam elem_t ELEM_MIN    = 32'sh8000_0000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    elem_t value;
    logic  final_item;
    logic  out_valid;
    logic  out_ready;
    elem_t sorted_value;
    logic  end_of_run;
    logic  truncated;

    // Bench copy of the element store and the open set.
    elem_t        held_elements [CAPACITY];
    int           held_count;
    logic         dropped_seen;
    sorted_beat_t expected_beats [$];
    sorted_beat_t front_beat;

    // Idle control, written by the test tasks and at start-up only.
    int send_gap_pct;
    int ready_stall_pct;
    int hold_requests;

    // Receiver state, written by the receiver process and at start-up only.
    int hold_served;
    int hold_left;
    int stall_left;

    // Run statistics.
    int unsigned cycle_count;
    int          error_count;
    int          items_sent;
    int          sets_closed;
    int          sets_truncated;
    int          beats_checked;

    ascending_bubble_sorter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .end_of_run   (end_of_run),
        .truncated    (truncated)
    );

    // Clock with a 12 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Free-running cycle counter for the timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d beats still expected",
                 cycle_count, expected_beats.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Counts one mismatch and prints a line for it while the count is at most 40.
    task automatic report_mismatch(input string what, input elem_t got, input elem_t want);
        error_count++;
        if (error_count <= 40)
        begin
            $display("MISMATCH beat %0d: %s got %0d expected %0d",
                     beats_checked, what, got, want);
        end
    endtask

    // Stores one element of the open set and, on the final beat, sorts the
    // set in place and queues its ascending read-out.
    function automatic void predict_sorted_beats(input elem_t v, input logic fin);
        int           i;
        int           j;
        elem_t        tmp;
        sorted_beat_t beat;
        if (held_count < CAPACITY)
        begin
            held_elements[held_count] = v;
            held_count++;
        end
        else
        begin
            dropped_seen = 1'b1;
        end
        if (!fin)
        begin
            return;
        end
        // Swap only on strictly greater so that equal elements keep their order.
        for (i = 0; i < held_count - 1; i++)
        begin
            for (j = 0; j + 1 < held_count - i; j++)
            begin
                if (held_elements[j] > held_elements[j + 1])
                begin
                    tmp                  = held_elements[j];
                    held_elements[j]     = held_elements[j + 1];
                    held_elements[j + 1] = tmp;
                end
            end
        end
        for (i = 0; i < held_count; i++)
        begin
            beat.value = held_elements[i];
            beat.last  = (i == held_count - 1);
            beat.trunc = dropped_seen;
            expected_beats.push_back(beat);
        end
        sets_closed++;
        if (dropped_seen)
        begin
            sets_truncated++;
        end
        held_count   = 0;
        dropped_seen = 1'b0;
    endfunction

    // Mostly full-range values, with small values for ties and the extremes.
    function automatic elem_t pick_value();
        int unsigned mode;
        mode = $urandom_range(9);
        if (mode < 6)
        begin
            return elem_t'($urandom);
        end
        else if (mode < 8)
        begin
            return elem_t'($urandom_range(8)) - 4;
        end
        else
        begin
            case ($urandom_range(5))
                0:       return ELEM_MIN;
                1:       return ELEM_MIN + 1;
                2:       return ELEM_MAX;
                3:       return ELEM_MAX - 1;
                4:       return -1;
                default: return 0;
            endcase
        end
    endfunction

    // Sends one beat, with an optional idle burst ahead of it. Valid is only
    // lowered by a burst or at the end of the run, never between two beats.
    task automatic send_element(input elem_t v, input logic fin);
        int gap;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        value      <= v;
        final_item <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        items_sent++;
        predict_sorted_beats(v, fin);
    endtask

    // Sends a set of random elements of the given size.
    task automatic send_random_set(input int size);
        int k;
        for (k = 0; k < size; k++)
        begin
            send_element(pick_value(), k == size - 1);
        end
    endtask

    // Receiver: long hold-offs on request, random stall bursts otherwise.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (ready_stall_pct > 0 && $urandom_range(99) < ready_stall_pct)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Checks every accepted output beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("beat with nothing expected, value", sorted_value, 0);
            end
            else
            begin
                front_beat = expected_beats.pop_front();
                if (sorted_value !== front_beat.value)
                begin
                    report_mismatch("sorted_value", sorted_value, front_beat.value);
                end
                if (end_of_run !== front_beat.last)
                begin
                    report_mismatch("end_of_run", elem_t'(end_of_run),
                                    elem_t'(front_beat.last));
                end
                if (truncated !== front_beat.trunc)
                begin
                    report_mismatch("truncated", elem_t'(truncated),
                                    elem_t'(front_beat.trunc));
                end
            end
            beats_checked++;
        end
    end

    // Extremes of the value range, with repeated values.
    task automatic test_extremes();
        send_gap_pct    = 30;
        ready_stall_pct = 30;
        send_element(ELEM_MAX, 1'b0);
        send_element(ELEM_MIN, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b0);
        send_element(1, 1'b0);
        send_element(ELEM_MIN, 1'b0);
        send_element(ELEM_MAX, 1'b1);
    endtask

    // Sets of one element, where no pass runs at all.
    task automatic test_single_element();
        send_element(-5, 1'b1);
        send_element(ELEM_MAX, 1'b1);
    endtask

    // Reversed input needs a swap at every compare.
    task automatic test_reversed();
        send_element(40, 1'b0);
        send_element(30, 1'b0);
        send_element(0, 1'b0);
        send_element(-30, 1'b0);
        send_element(-40, 1'b1);
    endtask

    // Already ascending input with ties needs no swap.
    task automatic test_presorted_ties();
        send_element(-2, 1'b0);
        send_element(-2, 1'b0);
        send_element(0, 1'b0);
        send_element(7, 1'b0);
        send_element(7, 1'b1);
    endtask

    // The final beat fills the store exactly, so nothing is dropped.
    task automatic test_full_store();
        send_random_set(CAPACITY);
    endtask

    // A middle beat and then the final beat arrive with the store full.
    task automatic test_overflow();
        send_random_set(CAPACITY + 2);
    endtask

    // The receiver holds off while several sets are offered, so the block
    // fills up and drops its input ready.
    task automatic test_receiver_backpressure();
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        hold_requests++;
        send_random_set(6);
        send_random_set(6);
        send_random_set(4);
    endtask

    // Random sets, mostly small, with idle bursts that change per set.
    task automatic test_random_sets(input int count);
        int target;
        int size;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                size = $urandom_range(1, 8);
            end
            else if (pick < 95)
            begin
                size = $urandom_range(9, 24);
            end
            else
            begin
                size = $urandom_range(25, 40);
            end
            send_gap_pct    = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
            ready_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
            send_random_set(size);
        end
    endtask

    // Back-to-back traffic with no idle cycles on either side.
    task automatic test_back_to_back(input int count);
        int target;
        target          = items_sent + count;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        while (items_sent < target)
        begin
            send_random_set($urandom_range(1, 10));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        value           = '0;
        final_item      = 1'b0;
        out_ready       = 1'b0;
        cycle_count     = 0;
        error_count     = 0;
        items_sent      = 0;
        sets_closed     = 0;
        sets_truncated  = 0;
        beats_checked   = 0;
        held_count      = 0;
        dropped_seen    = 1'b0;
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        stall_left      = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_single_element();
        test_reversed();
        test_presorted_ties();
        test_full_store();
        test_overflow();
        test_receiver_backpressure();
        test_random_sets(160);
        test_back_to_back(40);

        // Drain: wait for every predicted beat, then for any stray beat.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_beats.size() != 0)
        begin
            report_mismatch("beats never delivered, count",
                            elem_t'(expected_beats.size()), 0);
        end

        $display("Sent %0d elements in %0d sets (%0d truncated), checked %0d sorted beats.",
                 items_sent, sets_closed, sets_truncated, beats_checked);
        $display("Covered value extremes, ties, full and overflowing store, and output hold-off.");
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches found", error_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/abs_pkg.sv
rtl/abs_store.sv
rtl/abs_out.sv
rtl/abs_seq.sv
rtl/ascending_bubble_sorter.sv
bench/tb_ascending_bubble_sorter.sv
